@@ sv/qdr_pkg.sv @@
// Shared types, constants and microcode ROM of the quadrature decoder.
package qdr_pkg;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_PRIME  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DECODE,
    OP_MUL,
    OP_CHECK,
    OP_DIV,
    OP_FIN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_NO_SPEED,
    COND_MORE,
    COND_SKIP,
    COND_OUT_FREE
  } cond_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } ctrl_t;

  localparam step_t ST_ACCEPT = 3'd0;
  localparam step_t ST_DECODE = 3'd1;
  localparam step_t ST_MUL    = 3'd2;
  localparam step_t ST_CHECK  = 3'd3;
  localparam step_t ST_DIV    = 3'd4;
  localparam step_t ST_FIN    = 3'd5;
  localparam step_t ST_EMIT   = 3'd6;

  localparam int          DIGIT_W    = 16;
  localparam int          MULT_W     = 20;
  localparam int          PP_W       = DIGIT_W + MULT_W;
  localparam logic [19:0] RPM_MULT   = 20'd937500;
  localparam int          RPM_SHIFT  = 14;
  localparam int          PPR_W      = 16;
  localparam int          TIME_W     = 32;
  localparam int          DEN_W      = PPR_W + TIME_W;
  localparam int          QUO_W      = 32;
  localparam int          CNT_W      = 5;
  localparam logic [4:0]  DIV_LAST   = 5'd31;
  localparam logic [15:0] PPR_RESET  = 16'd1024;
  localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    unique case (s)
      ST_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_IN,       hold: 1'b1, target: ST_DECODE};
      ST_DECODE: w = '{op: OP_DECODE, cond: COND_NO_SPEED, hold: 1'b0, target: ST_EMIT};
      ST_MUL:    w = '{op: OP_MUL,    cond: COND_MORE,     hold: 1'b0, target: ST_MUL};
      ST_CHECK:  w = '{op: OP_CHECK,  cond: COND_SKIP,     hold: 1'b0, target: ST_FIN};
      ST_DIV:    w = '{op: OP_DIV,    cond: COND_MORE,     hold: 1'b0, target: ST_DIV};
      ST_FIN:    w = '{op: OP_FIN,    cond: COND_ALWAYS,   hold: 1'b0, target: ST_EMIT};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE, hold: 1'b1, target: ST_ACCEPT};
      default:   w = '{op: OP_ACCEPT, cond: COND_ALWAYS,   hold: 1'b0, target: ST_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic dir_t step_dir(input logic [1:0] prev, input logic [1:0] cur);
    dir_t d;
    unique case ({prev, cur})
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_UP;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_DOWN;
      default:                            d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

@@ sv/quadrature_decoder_with_rpm_top.sv @@
// Quadrature x4 decoder with position count and microcoded rpm measurement.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       action, pin_a, pin_b, now_us
//   out      source     out_valid / out_stall     position, speed_rpm_q8, speed_valid,
//                                                 last_update_us
//   config   sink       pulses_per_rev_we         pulses_per_rev
//
// Sample, clear, prime and the first query pass from accept through decode to emit.
// After decode, an armed speed query runs one 16x20
// multiply step per 16-bit digit of the count difference, then a 32-step
// restoring divide; a saturated or zero result skips the divide.
// rst is synchronous; it clears the sequencer, count, reference and output valid.
// A stalled result holds the sequencer at its emit step; the next transaction
// is accepted once the result register is loaded.
module quadrature_decoder_with_rpm_top
  import qdr_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic        pin_a,
  input  logic        pin_b,
  input  logic [31:0] now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] position,
  output logic [31:0] speed_rpm_q8,
  output logic        speed_valid,
  output logic [31:0] last_update_us,
  input  logic        pulses_per_rev_we,
  input  logic [15:0] pulses_per_rev
);

  localparam int MAG_DIGITS = (COUNT_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int MAG_W      = MAG_DIGITS * DIGIT_W;
  localparam int PROD_W     = MAG_W + MULT_W;
  localparam int NUM_W      = PROD_W + RPM_SHIFT;
  localparam int HI_W       = NUM_W - QUO_W;
  localparam int CMP_W      = (HI_W > DEN_W) ? HI_W : DEN_W;

  step_t                  pc;
  step_t                  pc_next;
  ctrl_t                  ctrl;
  logic                   cond_ok;
  logic                   in_fire;
  logic                   out_free;

  logic [PPR_W-1:0]       ppr;
  logic [1:0]             prev_pins;
  logic [COUNT_BITS-1:0]  pos_count;
  logic [COUNT_BITS-1:0]  ref_count;
  logic [TIME_W-1:0]      ref_time;
  logic                   speed_armed;
  logic [TIME_W-1:0]      sample_time;

  action_t                act_q;
  logic [1:0]             pins_q;
  logic [TIME_W-1:0]      now_q;
  logic                   do_speed;

  logic [MAG_W-1:0]       mag_sh;
  logic [PROD_W-1:0]      acc;
  logic [DEN_W-1:0]       den;
  logic [DEN_W-1:0]       rem;
  logic [QUO_W-1:0]       quo;
  logic [CNT_W-1:0]       cnt;
  logic                   neg;
  logic                   mag_zero;
  logic                   sat;
  logic [31:0]            speed_res;

  logic [COUNT_BITS-1:0]  diff;
  logic [COUNT_BITS-1:0]  mag_c;
  logic [TIME_W-1:0]      dt;
  logic [DEN_W-1:0]       den_c;
  logic [PP_W-1:0]        pp;
  logic [NUM_W-1:0]       num;
  logic [CMP_W-1:0]       hi_ext;
  logic [CMP_W-1:0]       den_ext;
  logic                   over;
  logic                   skip;
  logic [DEN_W:0]         rem_sh;
  logic                   rem_ge;
  logic [31:0]            cap;
  logic [31:0]            q_lim;
  logic [63:0]            pos_sext;
  dir_t                   dir;

  assign ctrl     = ucode(pc);
  assign in_stall = (pc != ST_ACCEPT);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign diff     = pos_count - ref_count;
  assign mag_c    = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
  assign dt       = now_q - ref_time;
  assign den_c    = DEN_W'(ppr) * DEN_W'(dt);
  assign pp       = PP_W'(mag_sh[MAG_W-1 -: DIGIT_W]) * PP_W'(RPM_MULT);
  assign num      = {acc, {RPM_SHIFT{1'b0}}};
  assign hi_ext   = CMP_W'(num[NUM_W-1:QUO_W]);
  assign den_ext  = CMP_W'(den);
  assign over     = (den == '0) || (hi_ext >= den_ext);
  assign skip     = mag_zero || over;
  assign rem_sh   = {rem, quo[QUO_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign cap      = neg ? SAT_NEG : SAT_POS;
  assign q_lim    = (sat || quo > cap) ? cap : quo;
  assign pos_sext = 64'($signed(pos_count));
  assign dir      = step_dir(prev_pins, pins_q);

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN:       cond_ok = in_fire;
      COND_NO_SPEED: cond_ok = !(act_q == ACT_QUERY && speed_armed);
      COND_MORE:     cond_ok = (cnt != '0);
      COND_SKIP:     cond_ok = skip;
      COND_OUT_FREE: cond_ok = out_free;
      default:       cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_ok) begin
      pc_next = ctrl.target;
    end else if (ctrl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr <= PPR_RESET;
    end else if (pulses_per_rev_we) begin
      ppr <= pulses_per_rev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins   <= '0;
      pos_count   <= '0;
      ref_count   <= '0;
      ref_time    <= '0;
      speed_armed <= 1'b0;
      sample_time <= '0;
      out_valid   <= 1'b0;
      do_speed    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && ctrl.op != OP_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_ACCEPT: begin
          if (in_fire) begin
            act_q  <= action_t'(action);
            pins_q <= {pin_a, pin_b};
            now_q  <= now_us;
          end
        end
        OP_DECODE: begin
          speed_res <= '0;
          do_speed  <= (act_q == ACT_QUERY) && speed_armed;
          unique case (act_q)
            ACT_SAMPLE: begin
              if (dir == DIR_UP) begin
                pos_count <= pos_count + 1'b1;
              end else if (dir == DIR_DOWN) begin
                pos_count <= pos_count - 1'b1;
              end
              prev_pins   <= pins_q;
              sample_time <= now_q;
            end
            ACT_QUERY: begin
              speed_armed <= 1'b1;
              ref_count   <= pos_count;
              ref_time    <= now_q;
              neg         <= diff[COUNT_BITS-1];
              mag_zero    <= (diff == '0);
              mag_sh      <= MAG_W'(mag_c);
              den         <= den_c;
              acc         <= '0;
              cnt         <= CNT_W'(MAG_DIGITS - 1);
            end
            ACT_CLEAR: begin
              pos_count   <= '0;
              sample_time <= now_q;
            end
            ACT_PRIME: begin
              prev_pins   <= pins_q;
              sample_time <= now_q;
            end
            default: begin
              prev_pins <= prev_pins;
            end
          endcase
        end
        OP_MUL: begin
          acc    <= (acc << DIGIT_W) + PROD_W'(pp);
          mag_sh <= mag_sh << DIGIT_W;
          cnt    <= cnt - 1'b1;
        end
        OP_CHECK: begin
          sat <= over;
          rem <= DEN_W'(hi_ext);
          quo <= num[QUO_W-1:0];
          cnt <= DIV_LAST;
        end
        OP_DIV: begin
          rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
          quo <= {quo[QUO_W-2:0], rem_ge};
          cnt <= cnt - 1'b1;
        end
        OP_FIN: begin
          if (mag_zero) begin
            speed_res <= '0;
          end else begin
            speed_res <= neg ? (32'd0 - q_lim) : q_lim;
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            position       <= pos_sext[31:0];
            speed_rpm_q8   <= speed_res;
            speed_valid    <= do_speed;
            last_update_us <= sample_time;
          end
        end
        default: begin
          do_speed <= do_speed;
        end
      endcase
    end
  end

  a_div_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (pc == ST_DIV) |-> (rem < den))
    else $error("divide remainder not below divisor");

  a_mul_only_query: assert property (@(posedge clk) disable iff (rst)
    (pc == ST_MUL) |-> (act_q == ACT_QUERY && do_speed))
    else $error("multiply step outside an armed speed query");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == ST_EMIT))
    else $error("result loaded outside emit step");

  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    (pc == ST_DIV && cnt == '0) |=> (pc == ST_FIN))
    else $error("divide loop did not finish into final step");

  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    pc <= ST_EMIT)
    else $error("sequencer step out of program");

endmodule
